>>> hdl/swr_pkg.sv
`timescale 1ns / 1ps

package swr_pkg;

    localparam int MAX_SIDE    = 32;
    localparam int IDX_W       = $clog2(MAX_SIDE);
    localparam int SIDE_W      = 6;
    localparam int CELL_W      = 11;
    localparam int OP_W        = 2;
    localparam int RADIUS_W    = 4;
    localparam int CELL_DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int CELL_ADDR_W = 2 * IDX_W;
    localparam int WIN_MAX     = 31;
    localparam int WIN_DEPTH   = WIN_MAX * WIN_MAX;
    localparam int WIN_ADDR_W  = $clog2(WIN_DEPTH);

    typedef logic [CELL_W-1:0]      cell_t;
    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [SIDE_W-1:0]      side_t;
    typedef logic [OP_W-1:0]        opcode_t;
    typedef logic [RADIUS_W-1:0]    radius_t;
    typedef logic [CELL_ADDR_W-1:0] cell_addr_t;
    typedef logic [WIN_ADDR_W-1:0]  win_addr_t;

    localparam opcode_t OP_INIT   = 2'd0;
    localparam opcode_t OP_ROTATE = 2'd1;
    localparam opcode_t OP_READ   = 2'd2;

    localparam side_t SIDE_RESET = 6'd32;

endpackage

>>> hdl/swr_if.sv
`timescale 1ns / 1ps

interface swr_in_if import swr_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    side_t   row;
    side_t   col;
    radius_t radius;
    logic    turn_counterclockwise;

    modport source (output valid, opcode, row, col, radius, turn_counterclockwise,
                    input ready);
    modport sink   (input valid, opcode, row, col, radius, turn_counterclockwise,
                    output ready);
endinterface

interface swr_out_if import swr_pkg::*; ();
    logic  valid;
    logic  ready;
    cell_t cell_value;
    logic  status;

    modport source (output valid, cell_value, status, input ready);
    modport sink   (input valid, cell_value, status, output ready);
endinterface

>>> hdl/square_window_rotator.sv
`timescale 1ns / 1ps

// Square window rotator: keeps a matrix of up to 32 by 32 eleven-bit cells.
// in_item carries one command (init, rotate, read) with a valid/ready
// handshake; out_item returns exactly one result item per command: the cell
// value for a read (0 otherwise) and status (1 = bad opcode, window or index
// outside the matrix, matrix untouched). cfg_wr_en/cfg_wr_data set the side.
// Commands are handled one at a time; in_item.ready is high only while idle.
// Steps per item, n = active side, s = 2*radius+1:
//   init   : n*n cells (one cell store write per cycle)
//   rotate : (copy pass of s*s cells into the window store, then write-back
//                       pass, one cell per cycle on each single-port side)
//   read   : synchronous read of the cell store
//   errors : straight to the result
// The cell store has one write and one read port, so every pass moves one
// cell per cycle. After reset the block runs a fill pass that writes the
// row-major count for side 32; in_item.ready stays low meanwhile.
// Results land in an output register: a stalled receiver holds the result
// while the next command is accepted and worked on; that command then waits
// for the register to empty before it finishes.
module square_window_rotator import swr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  side_t       cfg_wr_data,
    swr_in_if.sink      in_item,
    swr_out_if.source   out_item
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FILL   = 3'd1;
    localparam logic [2:0] S_COPY   = 3'd2;
    localparam logic [2:0] S_DRAIN1 = 3'd3;
    localparam logic [2:0] S_BACK   = 3'd4;
    localparam logic [2:0] S_DRAIN2 = 3'd5;
    localparam logic [2:0] S_RDWAIT = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // Memories
    cell_t cell_mem [CELL_DEPTH];
    cell_t win_mem  [WIN_DEPTH];

    // Control state
    logic [2:0] state_reg, state_next;
    side_t      side_reg;
    logic       boot_reg, boot_next;
    idx_t       i_reg, i_next;
    idx_t       j_reg, j_next;
    idx_t       last_reg, last_next;
    cell_t      cnt_reg, cnt_next;
    logic       cp_valid_reg;
    logic       wb_valid_reg;
    logic       out_valid_reg, out_valid_next;

    // Payload state
    idx_t       si_reg, si_next;
    idx_t       sj_reg, sj_next;
    logic       ccw_reg, ccw_next;
    cell_t      res_value_reg, res_value_next;
    logic       res_status_reg, res_status_next;
    win_addr_t  cp_addr_reg;
    cell_addr_t wb_addr_reg;
    cell_t      out_value_reg, out_value_next;
    logic       out_status_reg, out_status_next;

    // Memory ports
    cell_t      cell_rdata, win_rdata;
    cell_addr_t cr_addr, cw_addr;
    cell_t      cw_data;
    logic       cw_en;
    win_addr_t  win_idx;

    // Decode
    side_t      n_act;
    logic       accept;
    logic       step_last;
    logic [6:0] row_w, col_w, r_w, n_w;
    logic       rot_bad, rd_bad;
    side_t      row_m1, col_m1;
    idx_t       rev_i, rev_j, src_i, src_j;
    logic       out_free;

    assign n_act  = (side_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_reg;
    assign accept = in_item.valid && in_item.ready;

    assign row_w = {1'b0, in_item.row};
    assign col_w = {1'b0, in_item.col};
    assign r_w   = {3'b000, in_item.radius};
    assign n_w   = {1'b0, n_act};

    assign rot_bad = (row_w < r_w + 7'd1) || (row_w + r_w > n_w)
                  || (col_w < r_w + 7'd1) || (col_w + r_w > n_w);
    assign rd_bad  = (in_item.row == '0) || (row_w > n_w)
                  || (in_item.col == '0) || (col_w > n_w);

    assign row_m1 = in_item.row - 6'd1;
    assign col_m1 = in_item.col - 6'd1;

    // Source cell of window element (i, j) for the chosen direction
    assign rev_i = last_reg - i_reg;
    assign rev_j = last_reg - j_reg;
    assign src_i = ccw_reg ? (si_reg + j_reg) : (si_reg + rev_j);
    assign src_j = ccw_reg ? (sj_reg + rev_i) : (sj_reg + i_reg);

    // Window store index i*31 + j
    assign win_idx = {i_reg, {IDX_W{1'b0}}} - {{IDX_W{1'b0}}, i_reg}
                   + {{IDX_W{1'b0}}, j_reg};

    assign step_last = (i_reg == last_reg) && (j_reg == last_reg);
    assign out_free  = !out_valid_reg || out_item.ready;

    assign in_item.ready      = (state_reg == S_IDLE);
    assign out_item.valid     = out_valid_reg;
    assign out_item.cell_value = out_value_reg;
    assign out_item.status    = out_status_reg;

    // Cell store ports
    always_comb
    begin
        cr_addr = {src_i, src_j};
        if (state_reg == S_IDLE)
        begin
            cr_addr = {row_m1[IDX_W-1:0], col_m1[IDX_W-1:0]};
        end
        cw_en   = 1'b0;
        cw_addr = wb_addr_reg;
        cw_data = win_rdata;
        if (state_reg == S_FILL)
        begin
            cw_en   = 1'b1;
            cw_addr = {i_reg, j_reg};
            cw_data = cnt_reg;
        end
        else if (wb_valid_reg)
        begin
            cw_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cw_en)
        begin
            cell_mem[cw_addr] <= cw_data;
        end
        cell_rdata <= cell_mem[cr_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cp_valid_reg)
        begin
            win_mem[cp_addr_reg] <= cell_rdata;
        end
        win_rdata <= win_mem[win_idx];
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        boot_next       = boot_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        last_next       = last_reg;
        cnt_next        = cnt_reg;
        si_next         = si_reg;
        sj_next         = sj_reg;
        ccw_next        = ccw_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !out_item.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = 1'b0;
                    i_next          = '0;
                    j_next          = '0;
                    case (in_item.opcode)
                        OP_INIT:
                        begin
                            cnt_next  = cell_t'(1);
                            last_next = IDX_W'(n_act - 6'd1);
                            state_next = (n_act == '0) ? S_OUT : S_FILL;
                        end
                        OP_ROTATE:
                        begin
                            si_next   = row_m1[IDX_W-1:0] - {1'b0, in_item.radius};
                            sj_next   = col_m1[IDX_W-1:0] - {1'b0, in_item.radius};
                            last_next = {in_item.radius, 1'b0};
                            ccw_next  = in_item.turn_counterclockwise;
                            res_status_next = rot_bad;
                            state_next = rot_bad ? S_OUT : S_COPY;
                        end
                        OP_READ:
                        begin
                            res_status_next = rd_bad;
                            state_next = rd_bad ? S_OUT : S_RDWAIT;
                        end
                        default:
                        begin
                            res_status_next = 1'b1;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + cell_t'(1);
                if (j_reg == last_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + idx_t'(1);
                end
                else
                begin
                    j_next = j_reg + idx_t'(1);
                end
                if (step_last)
                begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_OUT;
                end
            end
            S_COPY, S_BACK:
            begin
                if (j_reg == last_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + idx_t'(1);
                end
                else
                begin
                    j_next = j_reg + idx_t'(1);
                end
                if (step_last)
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = (state_reg == S_COPY) ? S_DRAIN1 : S_DRAIN2;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_BACK;
            end
            S_DRAIN2:
            begin
                state_next = S_OUT;
            end
            S_RDWAIT:
            begin
                res_value_next = cell_rdata;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_FILL;
            boot_reg      <= 1'b1;
            side_reg      <= SIDE_RESET;
            i_reg         <= '0;
            j_reg         <= '0;
            last_reg      <= idx_t'(MAX_SIDE - 1);
            cnt_reg       <= cell_t'(1);
            cp_valid_reg  <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            boot_reg      <= boot_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            cp_valid_reg  <= (state_reg == S_COPY);
            wb_valid_reg  <= (state_reg == S_BACK);
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                side_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        si_reg         <= si_next;
        sj_reg         <= sj_next;
        ccw_reg        <= ccw_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        cp_addr_reg    <= win_idx;
        wb_addr_reg    <= {si_reg + i_reg, sj_reg + j_reg};
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    // Checks

    // Cell store is never written while the copy pass reads it
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cw_en && state_reg == S_COPY))
        else $error("cell store written during copy pass");

    // Window writes only happen in the copy pass or in the cycle after it
    assert property (@(posedge clk) disable iff (!rst_n)
        cp_valid_reg |-> (state_reg == S_COPY || state_reg == S_DRAIN1))
        else $error("window write outside copy pass");

    // A rejected rotate goes straight to the result with error status
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_item.opcode == OP_ROTATE && rot_bad)
        |=> (state_reg == S_OUT && res_status_reg))
        else $error("bad rotate window not flagged");

    // Loop counters stay inside the window while sweeping
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COPY || state_reg == S_BACK || state_reg == S_FILL)
        |-> (i_reg <= last_reg && j_reg <= last_reg))
        else $error("sweep counter beyond window");

    // One command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_item.ready)
        else $error("second item accepted while busy");

endmodule

>>> tb/square_window_rotator_checker.sv
`timescale 1ns / 1ps

// Watch both channels and the side register, keep a mirror of the cell
// matrix and compare every result item with the oldest outstanding one.
module square_window_rotator_checker import swr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  side_t     cfg_wr_data,
    swr_in_if         in_ch,
    swr_out_if        out_ch,
    output int        fail_count,
    output int        pending,
    output int        checked,
    output int        turns_applied,
    output int        refused
);

    typedef struct packed
    {
        cell_t value;
        logic  status;
    } cell_result_t;

    cell_t        cell_mirror [CELL_DEPTH];
    side_t        mirror_side;
    cell_result_t results_due [$];

    function automatic int active_side();
        return (int'(mirror_side) > MAX_SIDE) ? MAX_SIDE : int'(mirror_side);
    endfunction

    task automatic fill_count();
        int n;
        n = active_side();
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                cell_mirror[i * MAX_SIDE + j] = cell_t'(i * n + j + 1);
    endtask

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("[%0t ns] %s: expected %0d, got %0d", $time, what, want, got);
        fail_count++;
    endtask

    // Apply one command to the mirror and work out the result item it owes.
    task automatic predict_command(input opcode_t op, input side_t row_f, input side_t col_f,
                                   input radius_t rad_f, input logic ccw,
                                   output cell_result_t res);
        int    n, r, ri, ci, sz, si, sj, src_i, src_j;
        cell_t window_copy [WIN_DEPTH];
        n  = active_side();
        ri = int'(row_f);
        ci = int'(col_f);
        r  = int'(rad_f);
        res = '0;
        case (op)
            OP_INIT:
                fill_count();
            OP_ROTATE:
            begin
                if (ri < r + 1 || ri + r > n || ci < r + 1 || ci + r > n)
                    res.status = 1'b1;
                else
                begin
                    sz = 2 * r + 1;
                    si = ri - 1 - r;
                    sj = ci - 1 - r;
                    for (int i = 0; i < sz; i++)
                        for (int j = 0; j < sz; j++)
                        begin
                            if (ccw)
                            begin
                                src_i = si + j;
                                src_j = sj + (sz - 1 - i);
                            end
                            else
                            begin
                                src_i = si + (sz - 1 - j);
                                src_j = sj + i;
                            end
                            window_copy[i * WIN_MAX + j] = cell_mirror[src_i * MAX_SIDE + src_j];
                        end
                    for (int i = 0; i < sz; i++)
                        for (int j = 0; j < sz; j++)
                            cell_mirror[(si + i) * MAX_SIDE + sj + j] = window_copy[i * WIN_MAX + j];
                    turns_applied++;
                end
            end
            OP_READ:
            begin
                if (ri >= 1 && ri <= n && ci >= 1 && ci <= n)
                    res.value = cell_mirror[(ri - 1) * MAX_SIDE + ci - 1];
                else
                    res.status = 1'b1;
            end
            default:
                res.status = 1'b1;
        endcase
        if (res.status)
            refused++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cell_result_t due;
        cell_result_t fresh;
        if (!rst_n)
        begin
            mirror_side = SIDE_RESET;
            results_due.delete();
            fill_count();
            fail_count    = 0;
            pending       = 0;
            checked       = 0;
            turns_applied = 0;
            refused       = 0;
        end
        else
        begin
            // Retire the result first: it always belongs to an earlier command.
            if (out_ch.valid && out_ch.ready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result item with nothing outstanding, status",
                                    0, int'(out_ch.status));
                else
                begin
                    due = results_due.pop_front();
                    checked++;
                    if (out_ch.cell_value !== due.value)
                        report_mismatch("cell_value", int'(due.value), int'(out_ch.cell_value));
                    if (out_ch.status !== due.status)
                        report_mismatch("status", int'(due.status), int'(out_ch.status));
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predict_command(in_ch.opcode, in_ch.row, in_ch.col, in_ch.radius,
                                in_ch.turn_counterclockwise, fresh);
                results_due.push_back(fresh);
            end
            if (cfg_wr_en)
                mirror_side = cfg_wr_data;
            pending = results_due.size();
        end
    end

endmodule

>>> tb/square_window_rotator_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the square window rotator. The checker beside the
// block does all prediction; this module only offers commands, paces the
// receiver and decides pass or fail once everything has drained.
module square_window_rotator_tb;
    import swr_pkg::*;

    // Opcode 3 has no meaning in the block; it must come back refused.
    localparam opcode_t OP_UNUSED   = 2'd3;
    // Length of a deliberate receiver hold-off, long enough for the block to
    // fill its output register and then refuse further commands.
    localparam int      HOLD_CYCLES = 600;

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    side_t cfg_wr_data;

    swr_in_if  in_ch ();
    swr_out_if out_ch ();

    int fail_count;
    int pending;
    int checked;
    int turns_applied;
    int refused;

    // Stimulus shaping, written only by the main process.
    int cur_n        = 32;
    bit sender_gaps  = 1'b0;
    int burst_left   = 0;
    int recv_mode    = 0;
    int hold_asked   = 0;
    int sides_used   = 0;
    // Written only by the receiver process.
    int hold_taken   = 0;
    int stall_phase  = 0;

    square_window_rotator dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_item     (in_ch),
        .out_item    (out_ch)
    );

    square_window_rotator_checker matrix_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked),
        .turns_applied (turns_applied),
        .refused       (refused)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Give up well past the slowest legal run: every command a full-size
    // rotate, plus the power-up fill pass and every stall the receiver makes.
    initial
    begin
        #5_000_000;
        $display("square_window_rotator: mismatch");
        $finish;
    end

    // Receiver: stall on its own pattern, chosen per phase, and serve any
    // requested long hold-off by counting cycles here.
    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            stall_phase++;
            if (hold_taken != hold_asked)
            begin
                out_ch.ready <= 1'b0;
                for (int held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
                hold_taken++;
            end
            else
            begin
                case (recv_mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= ((stall_phase % 7) < 4);
                    default: out_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Offer one command and hold it until the block takes it. Between bursts
    // drop valid for a random gap so that idle cycles land on every phase.
    task automatic send_cmd(input opcode_t op, input int row_v, input int col_v,
                            input int rad_v, input bit ccw);
        int gap;
        if (sender_gaps && burst_left == 0)
        begin
            gap = $urandom_range(0, 9);
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_ch.valid                 <= 1'b1;
        in_ch.opcode                <= op;
        in_ch.row                   <= side_t'(row_v);
        in_ch.col                   <= side_t'(col_v);
        in_ch.radius                <= radius_t'(rad_v);
        in_ch.turn_counterclockwise <= ccw;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and wait for every outstanding result item. The first edge
    // is always taken so the checker has already counted the last command.
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write the side only once the block is idle.
    task automatic set_side(input int value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= side_t'(value);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cur_n = (value > MAX_SIDE) ? MAX_SIDE : value;
        sides_used++;
    endtask

    // Mostly well-formed rotates and reads inside the current matrix, with
    // the odd init, unused opcode and out-of-range noise mixed in. Radii are
    // kept small except now and then, which keeps the run short.
    task automatic random_commands(input int count);
        int pick, rmax, rad, row_v, col_v;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_cmd(OP_INIT, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            else if (pick < 52 && cur_n > 0)
            begin
                rmax = (cur_n - 1) / 2;
                if ($urandom_range(0, 11) == 0)
                    rad = $urandom_range(0, rmax);
                else
                    rad = $urandom_range(0, (rmax < 3) ? rmax : 3);
                row_v = $urandom_range(rad + 1, cur_n - rad);
                col_v = $urandom_range(rad + 1, cur_n - rad);
                send_cmd(OP_ROTATE, row_v, col_v, rad, 1'($urandom_range(0, 1)));
            end
            else if (pick < 88 && cur_n > 0)
                send_cmd(OP_READ, $urandom_range(1, cur_n), $urandom_range(1, cur_n),
                         $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            else if (pick < 93)
                send_cmd(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                         $urandom_range(0, 15), 1'($urandom_range(0, 1)));
            else
                send_cmd((pick < 97) ? OP_ROTATE : OP_READ, $urandom_range(0, 63),
                         $urandom_range(0, 63), $urandom_range(0, 15),
                         1'($urandom_range(0, 1)));
        end
    endtask

    // Pick fresh idling habits for a phase; sometimes none at all.
    task automatic shuffle_idling();
        sender_gaps = ($urandom_range(0, 2) != 0);
        recv_mode   = $urandom_range(0, 3);
    endtask

    initial
    begin
        rst_n                       <= 1'b0;
        cfg_wr_en                   <= 1'b0;
        cfg_wr_data                 <= '0;
        in_ch.valid                 <= 1'b0;
        in_ch.opcode                <= OP_INIT;
        in_ch.row                   <= '0;
        in_ch.col                   <= '0;
        in_ch.radius                <= '0;
        in_ch.turn_counterclockwise <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset side of 32; ready stays low through the
        // power-up fill, and send_cmd simply waits for it.
        recv_mode = 0;
        send_cmd(OP_READ, 1, 1, 0, 1'b0);
        send_cmd(OP_READ, 32, 32, 15, 1'b1);
        send_cmd(OP_READ, 0, 5, 0, 1'b0);         // row zero
        send_cmd(OP_READ, 5, 33, 0, 1'b0);        // column past the edge
        send_cmd(OP_ROTATE, 16, 16, 15, 1'b0);    // widest window, clockwise
        send_cmd(OP_READ, 1, 1, 0, 1'b0);
        send_cmd(OP_READ, 1, 32, 0, 1'b0);
        send_cmd(OP_ROTATE, 17, 17, 15, 1'b1);    // widest window touching far corner
        send_cmd(OP_READ, 32, 1, 0, 1'b0);
        send_cmd(OP_ROTATE, 3, 3, 2, 1'b0);
        send_cmd(OP_ROTATE, 1, 1, 0, 1'b1);       // single cell at the corner
        send_cmd(OP_ROTATE, 2, 2, 2, 1'b0);       // window off the top left
        send_cmd(OP_ROTATE, 31, 31, 2, 1'b1);     // window off the bottom right
        send_cmd(OP_ROTATE, 16, 18, 15, 1'b0);    // window one column too far
        send_cmd(OP_ROTATE, 63, 63, 0, 1'b1);     // centre far outside
        send_cmd(OP_UNUSED, 7, 7, 1, 1'b1);
        send_cmd(OP_READ, 3, 3, 0, 1'b0);
        send_cmd(OP_INIT, 0, 0, 0, 1'b0);
        send_cmd(OP_READ, 32, 32, 0, 1'b0);
        send_cmd(OP_READ, 7, 9, 0, 1'b0);

        // Side of one: a single cell, every window but radius zero refused.
        set_side(1);
        send_cmd(OP_INIT, 0, 0, 0, 1'b0);
        send_cmd(OP_READ, 1, 1, 0, 1'b0);
        send_cmd(OP_ROTATE, 1, 1, 0, 1'b1);
        send_cmd(OP_ROTATE, 1, 1, 1, 1'b0);
        send_cmd(OP_READ, 2, 1, 0, 1'b0);
        shuffle_idling();
        random_commands(10);

        // Side of zero: no cell exists, init still reports done.
        set_side(0);
        send_cmd(OP_INIT, 0, 0, 0, 1'b0);
        send_cmd(OP_ROTATE, 1, 1, 0, 1'b0);
        send_cmd(OP_READ, 1, 1, 0, 1'b0);

        // Oversized side saturates at 32; cells outside the old corner keep
        // whatever they held. Hold the receiver off while commands pile up.
        set_side(63);
        send_cmd(OP_READ, 32, 32, 0, 1'b0);
        sender_gaps = 1'b0;
        recv_mode   = 1;
        hold_asked++;
        random_commands(30);

        set_side(7);
        shuffle_idling();
        random_commands(40);

        set_side(2);
        shuffle_idling();
        random_commands(20);

        set_side(32);
        send_cmd(OP_INIT, 0, 0, 0, 1'b0);
        sender_gaps = 1'b0;
        recv_mode   = 2;
        hold_asked++;
        random_commands(60);

        for (int p = 0; p < 3; p++)
        begin
            set_side($urandom_range(1, 32));
            shuffle_idling();
            random_commands(35);
        end

        // Let everything drain, then allow a little slack for stray output.
        drain_results();
        repeat (16) @(posedge clk);

        $display("checked %0d result items: %0d window turns applied, %0d commands refused",
                 checked, turns_applied, refused);
        $display("side register written %0d times incl. 0, 1 and 63; %0d long receiver holds",
                 sides_used, hold_taken);
        if (fail_count == 0 && pending == 0)
            $display("square_window_rotator: match");
        else
            $display("square_window_rotator: mismatch");
        $finish;
    end

endmodule

>>> square_window_rotator.f
hdl/swr_pkg.sv
hdl/swr_if.sv
hdl/square_window_rotator.sv
tb/square_window_rotator_checker.sv
tb/square_window_rotator_tb.sv
